// ===== design/udiv_pkg.sv =====
// Package for the pipelined unsigned divider.
// Holds the default operand width shared by the cell, the output buffer and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package udiv_pkg;

	localparam int unsigned DIV_WIDTH = 64;

endpackage
`default_nettype wire

// ===== design/udiv_cell.sv =====
// One restoring-division cell: resolves one quotient bit and registers its state.
// Depends on udiv_pkg for the default width.
`timescale 1ns / 1ps
`default_nettype none
module udiv_cell #(
	parameter int unsigned DATA_WIDTH = udiv_pkg::DIV_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  valid_i,
	input  wire logic [DATA_WIDTH-1:0] rem_i,
	input  wire logic [DATA_WIDTH-1:0] num_i,
	input  wire logic [DATA_WIDTH-1:0] quo_i,
	input  wire logic [DATA_WIDTH-1:0] den_i,
	output logic                       valid_o,
	output logic [DATA_WIDTH-1:0]      rem_o,
	output logic [DATA_WIDTH-1:0]      num_o,
	output logic [DATA_WIDTH-1:0]      quo_o,
	output logic [DATA_WIDTH-1:0]      den_o
);
	import udiv_pkg::*;

	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;
	logic                  qbit;
	logic [DATA_WIDTH-1:0] rem_next;

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] num_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] den_q;

	always_comb begin
		trial    = {rem_i, num_i[DATA_WIDTH-1]};
		diff     = trial - {1'b0, den_i};
		qbit     = (trial >= {1'b0, den_i});
		rem_next = qbit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_next;
			num_q <= {num_i[DATA_WIDTH-2:0], 1'b0};
			quo_q <= {quo_i[DATA_WIDTH-2:0], qbit};
			den_q <= den_i;
		end
	end

	assign valid_o = valid_q;
	assign rem_o   = rem_q;
	assign num_o   = num_q;
	assign quo_o   = quo_q;
	assign den_o   = den_q;

endmodule
`default_nettype wire

// ===== design/udiv_out_buf.sv =====
// Output register with skid stage for the divider pipeline.
// Depends on udiv_pkg for the default width.
`timescale 1ns / 1ps
`default_nettype none
module udiv_out_buf #(
	parameter int unsigned DATA_WIDTH = udiv_pkg::DIV_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pipe_valid,
	input  wire logic [DATA_WIDTH-1:0] pipe_data,
	output logic                       pipe_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DATA_WIDTH-1:0]      out_data
);
	import udiv_pkg::*;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic                  skid_valid_q;
	logic [DATA_WIDTH-1:0] skid_data_q;
	logic                  take;
	logic                  drain;

	assign pipe_ready = !skid_valid_q;
	assign take       = pipe_valid && pipe_ready;
	assign drain      = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= take;
			end
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (take) begin
				out_data_q <= pipe_data;
			end
		end else if (take) begin
			skid_data_q <= pipe_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

// ===== design/unsigned_divider_64.sv =====
// Top level of the pipelined unsigned restoring divider: a chain of udiv_cell plus udiv_out_buf.
// Depends on udiv_pkg, udiv_cell and udiv_out_buf.
//
//   channel  | signals                               | direction
//   request  | in_valid, in_ready, dividend, divisor | in
//   result   | out_valid, out_ready, quotient        | out
//
// Accepts one request per cycle while in_ready is high; each request passes through the DATA_WIDTH
// cells, one quotient bit each, and then the output register before out_valid rises.
// Reset clears only the valid flags of the cells and the output buffer.
// While a result is stalled, the next one parks in the skid stage; the chain holds only
// while the skid stage is full.
// A zero divisor yields a zero quotient.
`timescale 1ns / 1ps
`default_nettype none
module unsigned_divider_64 #(
	parameter int unsigned DATA_WIDTH = udiv_pkg::DIV_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [DATA_WIDTH-1:0] dividend,
	input  wire logic [DATA_WIDTH-1:0] divisor,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DATA_WIDTH-1:0]      quotient
);
	import udiv_pkg::*;

	logic                  valid_c [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] rem_c   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] num_c   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] quo_c   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] den_c   [DATA_WIDTH+1];
	logic                  en;
	logic [DATA_WIDTH-1:0] result;

	assign valid_c[0] = in_valid;
	assign rem_c[0]   = '0;
	assign num_c[0]   = dividend;
	assign quo_c[0]   = '0;
	assign den_c[0]   = divisor;

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		udiv_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.valid_i(valid_c[i]),
			.rem_i  (rem_c[i]),
			.num_i  (num_c[i]),
			.quo_i  (quo_c[i]),
			.den_i  (den_c[i]),
			.valid_o(valid_c[i+1]),
			.rem_o  (rem_c[i+1]),
			.num_o  (num_c[i+1]),
			.quo_o  (quo_c[i+1]),
			.den_o  (den_c[i+1])
		);
	end

	assign in_ready = en;
	assign result   = (den_c[DATA_WIDTH] == '0) ? '0 : quo_c[DATA_WIDTH];

	udiv_out_buf #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.pipe_valid(valid_c[DATA_WIDTH]),
		.pipe_data (result),
		.pipe_ready(en),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (quotient)
	);

endmodule
`default_nettype wire

// ===== tb/quotient_checker.sv =====
// Checker for the unsigned divider: watches the request and result channels,
// predicts each quotient by restoring division and compares in order.
// Depends on udiv_pkg for the operand width.
`timescale 1ns / 1ps
module quotient_checker #(
	parameter int unsigned W = udiv_pkg::DIV_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_ready,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	input  logic         out_valid,
	input  logic         out_ready,
	input  logic [W-1:0] quotient,
	output int           mismatch_count,
	output int           quotients_pending
);

	logic [W-1:0] quotients_due[$];

	initial begin
		mismatch_count = 0;
		quotients_pending = 0;
	end

	function automatic logic [W-1:0] restoring_quotient(logic [W-1:0] num, logic [W-1:0] den);
		logic [W:0]   partial;
		logic [W-1:0] quo;
		partial = '0;
		quo = '0;
		if (den == '0)
			return '0;
		for (int b = W - 1; b >= 0; b--) begin
			partial = {partial[W-1:0], num[b]};
			if (partial >= {1'b0, den}) begin
				partial = partial - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
		if (mismatch_count < 40)
			$display("%0t: %s: got %h, want %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		logic [W-1:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (quotients_due.size() == 0) begin
					report_mismatch("quotient with no request outstanding", quotient, '0);
				end else begin
					want = quotients_due.pop_front();
					if (quotient !== want)
						report_mismatch("quotient", quotient, want);
				end
			end
			if (in_valid && in_ready)
				quotients_due.push_back(restoring_quotient(dividend, divisor));
			quotients_pending <= quotients_due.size();
		end
	end

	final begin
		if (quotients_due.size() != 0)
			$display("%0d quotients never arrived", quotients_due.size());
	end

endmodule

// ===== tb/unsigned_divider_64_tb.sv =====
// Testbench top for unsigned_divider_64: drives directed and random divisions with
// bursty requests and a patterned result stall. Depends on udiv_pkg, the divider
// and quotient_checker.
`timescale 1ns / 1ps
module unsigned_divider_64_tb;

	localparam int unsigned W = udiv_pkg::DIV_WIDTH;
	localparam logic [W-1:0] ALL_ONES = '1;
	localparam logic [W-1:0] TOP_BIT = {1'b1, {(W-1){1'b0}}};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         in_valid = 1'b0;
	logic         in_ready;
	logic [W-1:0] dividend = '0;
	logic [W-1:0] divisor = '0;
	logic         out_valid;
	logic         out_ready = 1'b0;
	logic [W-1:0] quotient;
	int           mismatch_count;
	int           quotients_pending;

	int           burst_left = 0;
	int           stall_cycle = 0;
	int           stall_mode = 0;

	unsigned_divider_64 uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.dividend(dividend),
		.divisor(divisor),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.quotient(quotient)
	);

	quotient_checker #(.W(W)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.dividend(dividend),
		.divisor(divisor),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.quotient(quotient),
		.mismatch_count(mismatch_count),
		.quotients_pending(quotients_pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: pick a new random stall pattern each time stall_cycle wraps
	always @(posedge clk) begin
		if (stall_cycle == 47) begin
			stall_cycle <= 0;
			stall_mode <= $urandom_range(0, 5);
		end else begin
			stall_cycle <= stall_cycle + 1;
		end
		case (stall_mode)
			0, 1: out_ready <= 1'b1;
			2: out_ready <= ($urandom_range(0, 3) != 0);
			3: out_ready <= 1'($urandom_range(0, 1));
			4: out_ready <= ((stall_cycle % 7) < 2);
			default: out_ready <= (stall_cycle < 30) ? 1'b0 : 1'b1;
		endcase
	end

	function automatic logic [W-1:0] random_word();
		return W'({$urandom, $urandom});
	endfunction

	task automatic issue_division(logic [W-1:0] num, logic [W-1:0] den);
		in_valid <= 1'b1;
		dividend <= num;
		divisor <= den;
		do @(posedge clk); while (!in_ready);
	endtask

	// end a burst with a random gap, or keep streaming
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (quotients_pending != 0);
	endtask

	initial begin
		logic [W-1:0] num_list[$];
		logic [W-1:0] den_list[$];
		logic [W-1:0] num;
		logic [W-1:0] den;
		num_list = '{'0, '0, ALL_ONES, ALL_ONES, ALL_ONES, W'(1), W'(12345),
			ALL_ONES - 1, ALL_ONES, TOP_BIT, TOP_BIT, TOP_BIT, W'(12345), ALL_ONES,
			ALL_ONES, W'(7), TOP_BIT - 1, {(W/2){2'b10}}, {(W/2){2'b01}}, ALL_ONES,
			W'(1) << (W/2), W'(100)};
		den_list = '{'0, W'(1), W'(1), ALL_ONES, '0, '0, '0, ALL_ONES, W'(2), W'(1),
			TOP_BIT, W'(3), W'(67), W'(1) << (W/2), ALL_ONES >> 1, W'(9), TOP_BIT,
			{(W/2){2'b01}}, {(W/2){2'b10}}, TOP_BIT + 1, (W'(1) << (W/2)) - 1, W'(100)};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (num_list[i]) begin
			issue_division(num_list[i], den_list[i]);
			pace();
		end
		drain();

		for (int n = 0; n < 450; n++) begin
			num = random_word();
			case ($urandom_range(0, 9))
				0: den = '0;
				1, 2: den = W'($urandom_range(1, 255));
				3: den = W'(1) << $urandom_range(0, W - 1);
				4: den = num >> $urandom_range(0, W - 1);
				5: den = num;
				6: den = random_word() >> $urandom_range(W / 2, W - 1);
				default: den = random_word();
			endcase
			case ($urandom_range(0, 9))
				0: num = num >> $urandom_range(1, W - 1);
				1: num = ALL_ONES;
				default: ;
			endcase
			issue_division(num, den);
			if (n == 200)
				drain();
			else
				pace();
		end

		drain();
		repeat (80) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/udiv_pkg.sv
design/udiv_cell.sv
design/udiv_out_buf.sv
design/unsigned_divider_64.sv
tb/quotient_checker.sv
tb/unsigned_divider_64_tb.sv
